@@ design/sxu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxu_pkg
// Shared types, codes and the CRC-16-CCITT byte step for the sysex unpacker.
// ----------------------------------------------------------------------------
package sxu_pkg;

  // Default number of data bytes ahead of each high-bit byte
  localparam int GROUP_LEN_DEF = 7;

  // Group buffer geometry (sized for the largest group)
  localparam int BUF_DEPTH = 8;
  localparam int BUF_AW    = 3;

  // CRC seed
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  // Command codes on func
  localparam logic [1:0] FUNC_FEED        = 2'd0;
  localparam logic [1:0] FUNC_RESTART_ALL = 2'd1;
  localparam logic [1:0] FUNC_RESTART_CRC = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] raw_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  decoded_byte;
    logic [15:0] crc_before;
    logic [15:0] crc_after;
    logic        last_of_group;
  } out_item_t;

  // Buffer write request
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // CRC-16-CCITT, poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [7:0]  q;
    logic [15:0] q16;
    t   = crc[15:8] ^ b;
    q   = t ^ (t >> 4);
    q16 = {8'h00, q};
    return {crc[7:0], 8'h00} ^ q16 ^ (q16 << 5) ^ (q16 << 12);
  endfunction

endpackage
`default_nettype wire

@@ design/sxu_buf_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sxu_buf_mem
// Group data buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sxu_buf_mem
  import sxu_pkg::*;
(
  input  wire logic              clk,
  input  wire buf_wr_t           wr,
  input  wire logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ design/sysex_unpack_crc16.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sysex_unpack_crc16
// MIDI sysex 7-bit unpacker with a running CRC-16-CCITT over decoded bytes.
// ----------------------------------------------------------------------------
// Data bytes and commands are taken from the input channel only while idle. The high-bit
// byte that closes a group starts a burst of GROUP_LEN results; during the burst
// the input is stalled. Each result is made in a buffer memory read state, then in
// a state that merges bit 7 and runs the CRC step into the output register; that
// state waits while the output side stalls. The read state is needed because the
// group buffer memory registers its read data.
module sysex_unpack_crc16
  import sxu_pkg::*;
#(
  parameter int GROUP_LEN = GROUP_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam logic [3:0]        GL       = 4'(GROUP_LEN);
  localparam logic [BUF_AW-1:0] LAST_IDX = BUF_AW'(GROUP_LEN - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [3:0]        fill_r, fill_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [BUF_AW-1:0] idx_r, idx_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  buf_wr_t     buf_wr;
  logic [7:0]  rd_data;
  logic        in_xfer;
  logic        out_free;
  logic        push;
  logic [7:0]  merged;
  logic [15:0] crc_step;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (state_r == ST_PUSH) && out_free;

  // Restore bit 7 and run the CRC over the byte
  assign merged   = rd_data | {hi_r[idx_r], 7'b0};
  assign crc_step = crc16_byte(crc_r, merged);

  sxu_buf_mem u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Control and datapath next state
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    crc_nxt       = crc_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    buf_wr.en     = 1'b0;
    buf_wr.addr   = fill_r[BUF_AW-1:0];
    buf_wr.data   = in_item.raw_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_item.func)
            FUNC_RESTART_ALL: begin
              fill_nxt = 4'd0;
              crc_nxt  = CRC_SEED;
            end
            FUNC_RESTART_CRC: begin
              crc_nxt = CRC_SEED;
            end
            FUNC_FEED: begin
              if (fill_r < GL) begin
                buf_wr.en = 1'b1;
                fill_nxt  = fill_r + 4'd1;
              end else begin
                // high-bit byte closes the group
                hi_nxt    = in_item.raw_byte;
                idx_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.decoded_byte  = merged;
          out_item_nxt.crc_before    = crc_r;
          out_item_nxt.crc_after     = crc_step;
          out_item_nxt.last_of_group = (idx_r == LAST_IDX);
          crc_nxt                    = crc_step;
          if (idx_r == LAST_IDX) begin
            fill_nxt  = 4'd0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= 4'd0;
      crc_r       <= CRC_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hi_r       <= hi_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= GL)
    else $error("fill count beyond group length");

  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (fill_r == GL))
    else $error("emitting from an incomplete group");

  a_crc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (out_item_r.crc_after == crc_r) && out_valid_r)
    else $error("running crc out of step with output");

  a_rise_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PUSH))
    else $error("output loaded outside the emit state");

endmodule
`default_nettype wire
